// ----- hdl/fst_pkg.sv -----
// flow statistics table package: result codes and the per-slot statistics record
// no dependencies
package fst_pkg;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int KEY_W = 97;

    typedef struct packed {
        logic [31:0] pkt;
        logic [47:0] lsum;
        logic [63:0] lsq;
        logic [15:0] lmin;
        logic [15:0] lmax;
        logic [47:0] first;
        logic [47:0] last;
        logic [47:0] gsum;
        logic [47:0] gmin;
        logic [47:0] gmax;
        logic [39:0] hsum;
    } t_stats;

    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } t_search;

endpackage

// ----- hdl/fst_key_search.sv -----
// flow key store and sequential exact-match scan over allocated slots
// depends on fst_pkg
module fst_key_search #(
    parameter int FLOW_SLOTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fst_pkg::KEY_W-1:0]         i_key,
    output fst_pkg::t_search                  o_res,
    output logic [$clog2(FLOW_SLOTS)-1:0]     o_index
);
    import fst_pkg::*;

    localparam int IW = $clog2(FLOW_SLOTS);
    localparam int CW = $clog2(FLOW_SLOTS + 1);

    logic [KEY_W-1:0] mem [FLOW_SLOTS];
    logic [KEY_W-1:0] r_rd_key;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_addr;
    logic             r_busy;
    logic             r_cmp_v;
    logic [IW-1:0]    r_cmp_idx;
    logic             issue;
    logic             match;
    logic             done;
    logic             full;

    assign issue = r_busy && (r_addr < r_count);
    assign match = r_busy && r_cmp_v && (r_rd_key == i_key);
    assign done  = match || (r_busy && !issue && !r_cmp_v);
    assign full  = r_count == CW'(FLOW_SLOTS);

    assign o_res.done = done;
    assign o_res.hit  = match;
    assign o_res.full = !match && full;
    assign o_index    = match ? r_cmp_idx : r_count[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_key <= mem[r_addr[IW-1:0]];
        end
        if (done && !match && !full) begin
            mem[r_count[IW-1:0]] <= i_key;
        end
        r_cmp_idx <= r_addr[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_addr  <= '0;
            r_busy  <= 1'b0;
            r_cmp_v <= 1'b0;
        end else if (i_start) begin
            r_addr  <= '0;
            r_busy  <= 1'b1;
            r_cmp_v <= 1'b0;
        end else if (done) begin
            r_busy  <= 1'b0;
            r_cmp_v <= 1'b0;
            if (!match && !full) begin
                r_count <= r_count + CW'(1);
            end
        end else begin
            r_cmp_v <= issue;
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end
        end
    end

endmodule

// ----- hdl/flow_statistics_table_unit.sv -----
// the key scan reads one stored key per cycle, over the slots allocated so far
// one packet at a time: a new input transfer is taken only once the result of the
// last packet has been registered for output
// a result waiting on the output does not block the next input transfer
// reset (synchronous, active low) empties the table at once; no clearing pass
// top level of the flow statistics table, depends on fst_pkg and fst_key_search
module flow_statistics_table_unit #(
    parameter int FLOW_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic        i_is_tcp,
    input  logic [15:0] i_ip_length,
    input  logic [47:0] i_time_us,
    input  logic [3:0]  i_tcp_offset_words,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot_index,
    output logic [31:0] o_packet_total,
    output logic [47:0] o_length_total,
    output logic [63:0] o_length_square_total,
    output logic [15:0] o_length_least,
    output logic [15:0] o_length_most,
    output logic [47:0] o_gap_total,
    output logic [47:0] o_gap_least,
    output logic [47:0] o_gap_most,
    output logic [39:0] o_header_total,
    output logic [47:0] o_duration_us
);
    import fst_pkg::*;

    localparam int IW = $clog2(FLOW_SLOTS);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_CALC   = 2'd2;

    t_stats mem [FLOW_SLOTS];
    t_stats r_rd;
    t_stats n_st;

    logic [1:0]       r_state;
    logic             r_start;
    logic [KEY_W-1:0] r_key;
    logic [15:0]      r_len;
    logic [31:0]      r_sq;
    logic [47:0]      r_time;
    logic [6:0]       r_hdr;
    logic [1:0]       r_kind;
    logic [IW-1:0]    r_idx;
    t_search          srch;
    logic [IW-1:0]    srch_idx;
    logic             fire;

    logic [47:0] gap;
    logic [32:0] s_pkt;
    logic [48:0] s_len;
    logic [64:0] s_sq;
    logic [48:0] s_gap;
    logic [40:0] s_hdr;
    logic [IW+7:0] idx_ext;

    logic [1:0]  r_o_status;
    logic [7:0]  r_o_slot;
    t_stats      r_o_st;
    logic [47:0] r_o_dur;
    logic        r_out_valid;

    fst_key_search #(.FLOW_SLOTS(FLOW_SLOTS)) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_key   (r_key),
        .o_res   (srch),
        .o_index (srch_idx)
    );

    assign o_ready = r_state == S_IDLE;
    assign fire    = (r_state == S_CALC) && (!r_out_valid || i_ready);

    always_comb begin
        gap   = (r_time >= r_rd.last) ? r_time - r_rd.last : 48'd0;
        s_pkt = {1'b0, r_rd.pkt} + 33'd1;
        s_len = {1'b0, r_rd.lsum} + {33'd0, r_len};
        s_sq  = {1'b0, r_rd.lsq} + {33'd0, r_sq};
        s_gap = {1'b0, r_rd.gsum} + {1'b0, gap};
        s_hdr = {1'b0, r_rd.hsum} + {34'd0, r_hdr};
        n_st  = r_rd;
        unique case (r_kind)
            ST_UPDATED: begin
                n_st.pkt  = s_pkt[32] ? '1 : s_pkt[31:0];
                n_st.lsum = s_len[48] ? '1 : s_len[47:0];
                n_st.lsq  = s_sq[64]  ? '1 : s_sq[63:0];
                n_st.lmin = (r_len < r_rd.lmin) ? r_len : r_rd.lmin;
                n_st.lmax = (r_len > r_rd.lmax) ? r_len : r_rd.lmax;
                n_st.last = r_time;
                n_st.gsum = s_gap[48] ? '1 : s_gap[47:0];
                n_st.gmin = (gap < r_rd.gmin) ? gap : r_rd.gmin;
                n_st.gmax = (gap > r_rd.gmax) ? gap : r_rd.gmax;
                n_st.hsum = s_hdr[40] ? '1 : s_hdr[39:0];
            end
            ST_NEW: begin
                n_st.pkt   = 32'd1;
                n_st.lsum  = {32'd0, r_len};
                n_st.lsq   = {32'd0, r_sq};
                n_st.lmin  = r_len;
                n_st.lmax  = r_len;
                n_st.first = r_time;
                n_st.last  = r_time;
                n_st.gsum  = '0;
                n_st.gmin  = '1;
                n_st.gmax  = '0;
                n_st.hsum  = {33'd0, r_hdr};
            end
            default: begin
                n_st = '0;
            end
        endcase
    end

    assign idx_ext = {8'd0, r_idx};

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_key  <= {i_source_address, i_dest_address, i_source_port, i_dest_port, i_is_tcp};
            r_len  <= i_ip_length;
            r_sq   <= i_ip_length * i_ip_length;
            r_time <= i_time_us;
            r_hdr  <= i_is_tcp ? {1'b0, i_tcp_offset_words, 2'b00} : 7'd8;
        end
        if (r_state == S_SEARCH && srch.done) begin
            r_rd  <= mem[srch_idx];
            r_idx <= srch_idx;
            r_kind <= srch.full ? ST_FULL : (srch.hit ? ST_UPDATED : ST_NEW);
        end
        if (fire) begin
            if (r_kind != ST_FULL) begin
                mem[r_idx] <= n_st;
            end
            r_o_status <= r_kind;
            r_o_slot   <= (r_kind == ST_FULL) ? 8'd0 : idx_ext[7:0];
            r_o_st     <= n_st;
            r_o_dur    <= (r_kind == ST_UPDATED && r_time >= r_rd.first)
                          ? r_time - r_rd.first : 48'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SEARCH;
                        r_start <= 1'b1;
                    end
                end
                S_SEARCH: begin
                    if (srch.done && !r_start) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid               = r_out_valid;
    assign o_status              = r_o_status;
    assign o_slot_index          = r_o_slot;
    assign o_packet_total        = r_o_st.pkt;
    assign o_length_total        = r_o_st.lsum;
    assign o_length_square_total = r_o_st.lsq;
    assign o_length_least        = r_o_st.lmin;
    assign o_length_most         = r_o_st.lmax;
    assign o_gap_total           = r_o_st.gsum;
    assign o_gap_least           = r_o_st.gmin;
    assign o_gap_most            = r_o_st.gmax;
    assign o_header_total        = r_o_st.hsum;
    assign o_duration_us         = r_o_dur;

endmodule

// ----- hdl/fst_checker.sv -----
// port-level checks for the flow statistics table, bound to the top level
// depends on fst_pkg
module fst_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [7:0]  o_slot_index,
    input logic [31:0] o_packet_total,
    input logic [47:0] o_duration_us
);
    import fst_pkg::*;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_UPDATED || o_status == ST_NEW || o_status == ST_FULL))
        else $error("bad status code");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_slot_index == 8'd0 && o_packet_total == 32'd0))
        else $error("full result not zeroed");

    a_new_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NEW) |-> (o_packet_total == 32'd1 && o_duration_us == 48'd0))
        else $error("new flow not initialized");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_packet_total)))
        else $error("result dropped while stalled");

endmodule

bind flow_statistics_table_unit fst_port_checker u_fst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_slot_index   (o_slot_index),
    .o_packet_total (o_packet_total),
    .o_duration_us  (o_duration_us)
);

// ----- tb/sv/fst_checker.sv -----
// flow statistics table checker: watches both channels, keeps its own flow table
// and compares every result transfer; depends on fst_pkg
module fst_checker #(
    parameter int FLOW_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic        i_is_tcp,
    input  logic [15:0] i_ip_length,
    input  logic [47:0] i_time_us,
    input  logic [3:0]  i_tcp_offset_words,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [1:0]  o_status,
    input  logic [7:0]  o_slot_index,
    input  logic [31:0] o_packet_total,
    input  logic [47:0] o_length_total,
    input  logic [63:0] o_length_square_total,
    input  logic [15:0] o_length_least,
    input  logic [15:0] o_length_most,
    input  logic [47:0] o_gap_total,
    input  logic [47:0] o_gap_least,
    input  logic [47:0] o_gap_most,
    input  logic [39:0] o_header_total,
    input  logic [47:0] o_duration_us,
    output int          o_errors,
    output int          o_pending
);
    import fst_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [31:0] pkt;
        logic [47:0] lsum;
        logic [63:0] lsq;
        logic [15:0] lmin;
        logic [15:0] lmax;
        logic [47:0] gsum;
        logic [47:0] gmin;
        logic [47:0] gmax;
        logic [39:0] hsum;
        logic [47:0] dur;
    } t_flow_result;

    logic             flow_live [FLOW_SLOTS];
    logic [KEY_W-1:0] flow_key  [FLOW_SLOTS];
    t_stats           flow_acc  [FLOW_SLOTS];
    t_flow_result     result_queue [$];

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, int w);
        logic [64:0] s;
        logic [63:0] lim;
        lim = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[63:0];
    endfunction

    task automatic update_flow_table();
        logic [KEY_W-1:0] key;
        logic [39:0]      hdr;
        logic [47:0]      gap;
        logic [31:0]      sq;
        int               hit;
        int               fresh;
        int               s;
        t_stats           a;
        t_flow_result     r;
        key = {i_source_address, i_dest_address, i_source_port, i_dest_port, i_is_tcp};
        hdr = i_is_tcp ? 40'(i_tcp_offset_words) * 40'd4 : 40'd8;
        sq = i_ip_length * i_ip_length;
        hit = -1;
        fresh = -1;
        r = '0;
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (flow_live[i]) begin
                if (hit < 0 && flow_key[i] == key) hit = i;
            end else if (fresh < 0) begin
                fresh = i;
            end
        end
        if (hit < 0 && fresh < 0) begin
            r.status = ST_FULL;
            result_queue.push_back(r);
            return;
        end
        if (hit >= 0) begin
            s = hit;
            a = flow_acc[s];
            r.status = ST_UPDATED;
            gap = (i_time_us >= a.last) ? i_time_us - a.last : '0;
            a.pkt  = 32'(sat_add(64'(a.pkt), 64'd1, 32));
            a.lsum = 48'(sat_add(64'(a.lsum), 64'(i_ip_length), 48));
            a.lsq  = sat_add(a.lsq, 64'(sq), 64);
            if (i_ip_length < a.lmin) a.lmin = i_ip_length;
            if (i_ip_length > a.lmax) a.lmax = i_ip_length;
            a.last = i_time_us;
            a.gsum = 48'(sat_add(64'(a.gsum), 64'(gap), 48));
            if (gap < a.gmin) a.gmin = gap;
            if (gap > a.gmax) a.gmax = gap;
            a.hsum = 40'(sat_add(64'(a.hsum), 64'(hdr), 40));
        end else begin
            s = fresh;
            r.status = ST_NEW;
            flow_live[s] = 1'b1;
            flow_key[s] = key;
            a.pkt = 32'd1;
            a.lsum = 48'(i_ip_length);
            a.lsq = 64'(sq);
            a.lmin = i_ip_length;
            a.lmax = i_ip_length;
            a.first = i_time_us;
            a.last = i_time_us;
            a.gsum = '0;
            a.gmin = '1;
            a.gmax = '0;
            a.hsum = hdr;
        end
        flow_acc[s] = a;
        r.slot = s[7:0];
        r.pkt = a.pkt;
        r.lsum = a.lsum;
        r.lsq = a.lsq;
        r.lmin = a.lmin;
        r.lmax = a.lmax;
        r.gsum = a.gsum;
        r.gmin = a.gmin;
        r.gmax = a.gmax;
        r.hsum = a.hsum;
        r.dur = (a.last >= a.first) ? a.last - a.first : '0;
        result_queue.push_back(r);
    endtask

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            o_errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_flow_result e;
        if (!i_rst_n) begin
            o_errors = 0;
            for (int i = 0; i < FLOW_SLOTS; i++) flow_live[i] = 1'b0;
            result_queue.delete();
        end else begin
            if (i_valid && o_ready) update_flow_table();
            if (o_valid && i_ready) begin
                if (result_queue.size() == 0) begin
                    o_errors++;
                    $display("%0t unexpected result transfer: expected none actual status %0d",
                             $time, o_status);
                end else begin
                    e = result_queue.pop_front();
                    compare_field("status", 64'(e.status), 64'(o_status));
                    compare_field("slot_index", 64'(e.slot), 64'(o_slot_index));
                    compare_field("packet_total", 64'(e.pkt), 64'(o_packet_total));
                    compare_field("length_total", 64'(e.lsum), 64'(o_length_total));
                    compare_field("length_square_total", e.lsq, o_length_square_total);
                    compare_field("length_least", 64'(e.lmin), 64'(o_length_least));
                    compare_field("length_most", 64'(e.lmax), 64'(o_length_most));
                    compare_field("gap_total", 64'(e.gsum), 64'(o_gap_total));
                    compare_field("gap_least", 64'(e.gmin), 64'(o_gap_least));
                    compare_field("gap_most", 64'(e.gmax), 64'(o_gap_most));
                    compare_field("header_total", 64'(e.hsum), 64'(o_header_total));
                    compare_field("duration_us", 64'(e.dur), 64'(o_duration_us));
                end
            end
        end
        o_pending = result_queue.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// flow statistics table testbench top: clock, reset, packet stimulus and verdict
// depends on fst_pkg, flow_statistics_table_unit and fst_checker
module tb;
    import fst_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_source_address = '0;
    logic [31:0] i_dest_address = '0;
    logic [15:0] i_source_port = '0;
    logic [15:0] i_dest_port = '0;
    logic        i_is_tcp = 1'b0;
    logic [15:0] i_ip_length = '0;
    logic [47:0] i_time_us = '0;
    logic [3:0]  i_tcp_offset_words = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_slot_index;
    logic [31:0] o_packet_total;
    logic [47:0] o_length_total;
    logic [63:0] o_length_square_total;
    logic [15:0] o_length_least;
    logic [15:0] o_length_most;
    logic [47:0] o_gap_total;
    logic [47:0] o_gap_least;
    logic [47:0] o_gap_most;
    logic [39:0] o_header_total;
    logic [47:0] o_duration_us;
    int          errors;
    int          pending;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        tcp;
    } t_flow_key;

    t_flow_key   known_flows [$];
    logic [47:0] clock_us;
    int          burst_left;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    flow_statistics_table_unit uut (.*);

    fst_checker chk (.*, .o_errors(errors), .o_pending(pending));

    // receiver stall pattern, its mode repicked at random periodically
    int stall_mode = 0;
    int cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= ((cyc / 5) % 3 != 0);
        endcase
    end

    task automatic send_packet(t_flow_key k, logic [15:0] len, logic [47:0] t,
                               logic [3:0] off);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_source_address <= k.src;
        i_dest_address <= k.dst;
        i_source_port <= k.sport;
        i_dest_port <= k.dport;
        i_is_tcp <= k.tcp;
        i_ip_length <= len;
        i_time_us <= t;
        i_tcp_offset_words <= off;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic t_flow_key rand_key();
        t_flow_key k;
        k = {$urandom, $urandom, 16'($urandom), 16'($urandom), 1'($urandom)};
        if ($urandom_range(0, 9) == 0) k.src = '1;
        if ($urandom_range(0, 9) == 0) k.dport = '0;
        return k;
    endfunction

    initial begin
        t_flow_key   k;
        t_flow_key   m;
        logic [15:0] len;
        burst_left = 0;
        clock_us = 48'd1000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, protocol and direction, backward time, gap saturation
        k = '0;
        send_packet(k, 16'd0, 48'd0, 4'd0);
        send_packet(k, 16'hffff, 48'd5, 4'd15);
        send_packet(k, 16'd100, 48'd3, 4'd5);
        k.tcp = 1'b1;
        send_packet(k, 16'd40, 48'd10, 4'd15);
        send_packet(k, 16'd40, 48'd20, 4'd0);
        send_packet(k, 16'd60, 48'd20, 4'd4);
        k = '1;
        send_packet(k, 16'hffff, 48'hffff_ffff_ffff, 4'd15);
        send_packet(k, 16'hffff, 48'd0, 4'd15);
        send_packet(k, 16'hffff, 48'hffff_ffff_ffff, 4'd15);
        send_packet(k, 16'd0, 48'd0, 4'd15);
        send_packet(k, 16'd1, 48'hffff_ffff_ffff, 4'd15);
        m = '1;
        m.tcp = 1'b0;
        send_packet(m, 16'd20, 48'd7, 4'd9);
        m = {32'h0a00_0001, 32'h0a00_0002, 16'd80, 16'd443, 1'b1};
        send_packet(m, 16'd52, 48'd100, 4'd5);
        m = {32'h0a00_0002, 32'h0a00_0001, 16'd443, 16'd80, 1'b1};
        send_packet(m, 16'd1500, 48'd110, 4'd8);
        send_packet(m, 16'd1500, 48'd110, 4'd8);
        send_packet(m, 16'd9, 48'd500, 4'd8);

        // random: reuse of live flows, new flows until the table overflows
        for (int n = 0; n < 1250; n++) begin
            if (known_flows.size() == 0 || $urandom_range(0, 3) == 0) begin
                k = rand_key();
                if (known_flows.size() < 400) known_flows.push_back(k);
            end else begin
                k = known_flows[$urandom_range(0, known_flows.size() - 1)];
            end
            case ($urandom_range(0, 9))
                0: len = 16'd0;
                1: len = 16'hffff;
                default: len = 16'($urandom);
            endcase
            case ($urandom_range(0, 19))
                0: clock_us = rand48();
                1: clock_us = clock_us - 48'($urandom_range(1, 5000));
                default: clock_us = clock_us + 48'($urandom_range(0, 100000));
            endcase
            send_packet(k, len, clock_us, 4'($urandom));
        end
        i_valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("Verification failed");
        $finish;
    end

endmodule
